// File: hdl/size_class_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the size class slot allocator
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define SZAL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("size_class_slot_allocator assertion failed");

// next-cycle implication, checked out of reset
`define SZAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("size_class_slot_allocator assertion failed");

`endif

// File: hdl/szal_pkg.sv
// ----------------------------------------------------------------------------
// szal_pkg
// Types, codes and helpers shared by the size class slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package szal_pkg;

	localparam int NUM_CLASSES_DEF = 8;
	localparam int MAX_SLOTS_DEF   = 1024;

	// bitmap row width
	localparam int ROW_BITS = 32;

	// function codes
	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// status codes
	localparam logic [2:0] ST_GRANTED    = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
	localparam logic [2:0] ST_NO_SLOT    = 3'd2;
	localparam logic [2:0] ST_RELEASED   = 3'd3;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd4;

	// register indexes
	localparam logic [1:0] CFG_SIZES_LO  = 2'd0;
	localparam logic [1:0] CFG_SIZES_HI  = 2'd1;
	localparam logic [1:0] CFG_COUNTS_LO = 2'd2;
	localparam logic [1:0] CFG_COUNTS_HI = 2'd3;

	localparam logic [63:0] SIZES_LO_RST  = 64'd18015498088222720;
	localparam logic [63:0] SIZES_HI_RST  = 64'd281492157104144;
	localparam logic [63:0] COUNTS_LO_RST = 64'd4503633987239937;
	localparam logic [63:0] COUNTS_HI_RST = 64'd288231475680116800;

	typedef struct packed {
		logic        func;
		logic [29:0] request_bytes;
		logic [29:0] release_offset;
	} in_item_t;

	typedef struct packed {
		logic [29:0] grant_offset;
		logic [2:0]  status;
	} out_item_t;

	// 16-bit field of class c from a pair of packed registers
	function automatic logic [15:0] field16(input logic [63:0] lo, input logic [63:0] hi,
		input logic [2:0] c);
		logic [63:0] w;
		w = c[2] ? hi : lo;
		case (c[1:0])
			2'd0:    return w[15:0];
			2'd1:    return w[31:16];
			2'd2:    return w[47:32];
			default: return w[63:48];
		endcase
	endfunction

endpackage

`default_nettype wire

// File: hdl/szal_bitmap.sv
// ----------------------------------------------------------------------------
// szal_bitmap
// Slot usage bitmap memory, one row per word, with a clearing sweep at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module szal_bitmap #(
	parameter int ROWS = 256,
	parameter int AW   = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [AW-1:0]                 rd_addr,
	output logic      [szal_pkg::ROW_BITS-1:0] rd_data,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [szal_pkg::ROW_BITS-1:0] wr_data,
	output logic                               clearing
);

	logic [szal_pkg::ROW_BITS-1:0] mem [ROWS];
	logic [AW-1:0] clr_addr_q;
	logic          clr_q;

	// clearing sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clr_q;

endmodule

`default_nettype wire

// File: hdl/szal_mul.sv
// ----------------------------------------------------------------------------
// szal_mul
// Shared 16x16 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module szal_mul (
	input  wire logic        clk,
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	output logic      [31:0] p
);

	always_ff @(posedge clk) begin
		p <= 32'(a) * 32'(b);
	end

endmodule

`default_nettype wire

// File: hdl/szal_div.sv
// ----------------------------------------------------------------------------
// szal_div
// Restoring divider, one quotient bit per cycle, quotient of QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module szal_div #(
	parameter int QW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   num,
	input  wire logic [15:0]   den,
	output logic               done,
	output logic      [QW-1:0] quo
);

	localparam int DW = 16 + QW;
	localparam int KW = (QW > 1) ? $clog2(QW) : 1;

	logic [31:0]   rem_q;
	logic [DW-1:0] d_q;
	logic [KW-1:0] k_q;
	logic          busy_q;
	logic          done_q;
	logic [QW-1:0] quo_q;
	logic          ge;

	assign ge = rem_q >= 32'(d_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= KW'(QW - 1);
			end else if (busy_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - KW'(1);
				end
			end
		end
	end

	// datapath, divisor aligned to the top quotient bit then shifted down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			d_q   <= DW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - 32'(d_q);
			end
			d_q   <= d_q >> 1;
			quo_q <= QW'({quo_q, ge});
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: hdl/size_class_slot_allocator.sv
// ----------------------------------------------------------------------------
// size_class_slot_allocator
// Segregated-fit pool allocator: size class pick, bitmap scan, release.
//
//  channel | direction | handshake          | beat
//  in      | to block  | in_valid/in_stall  | in_data (func, bytes, offset)
//  out     | from block| out_valid/out_stall| out_data (offset, status)
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Allocate: probes one class at a time, then reads and checks bitmap rows, then
// sums the offset on the shared multiplier.
// Release: checks one region at a time, divides on the divider,
// then does a read-modify-write of the bitmap row.
// Reset: a clearing pass over NUM_CLASSES*ceil(MAX_SLOTS/32) bitmap rows (256 by
// default) runs before any beat is taken. A result holds while out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_class_slot_allocator_macros.svh"

module size_class_slot_allocator #(
	parameter int NUM_CLASSES = szal_pkg::NUM_CLASSES_DEF,
	parameter int MAX_SLOTS   = szal_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire szal_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output szal_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [63:0]         cfg_data
);

	localparam int RB   = szal_pkg::ROW_BITS;
	localparam int WPC  = (MAX_SLOTS + RB - 1) / RB;
	localparam int ROWS = NUM_CLASSES * WPC;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WW   = (WPC > 1) ? $clog2(WPC) : 1;
	localparam int QW   = $clog2(MAX_SLOTS + 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_ACLS = 4'd2;
	localparam logic [3:0] ST_ARD  = 4'd3;
	localparam logic [3:0] ST_ACHK = 4'd4;
	localparam logic [3:0] ST_AOFS = 4'd5;
	localparam logic [3:0] ST_AOFA = 4'd6;
	localparam logic [3:0] ST_API  = 4'd7;
	localparam logic [3:0] ST_APA  = 4'd8;
	localparam logic [3:0] ST_RPI  = 4'd9;
	localparam logic [3:0] ST_RPC  = 4'd10;
	localparam logic [3:0] ST_RDIV = 4'd11;
	localparam logic [3:0] ST_RRD  = 4'd12;
	localparam logic [3:0] ST_RWB  = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	logic [63:0] sizes_lo_q, sizes_hi_q, counts_lo_q, counts_hi_q;
	logic [3:0]  state_q;
	logic [2:0]  cls_q;
	logic [3:0]  ci_q;
	logic [WW-1:0] word_q;
	logic [15:0] slot_q;
	logic [31:0] acc_q;
	logic [29:0] rest_q;
	logic [29:0] req_q;
	szal_pkg::out_item_t res_q;
	szal_pkg::out_item_t out_q;
	logic        out_valid_q;

	logic          clearing;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [RB-1:0] rd_data, wr_data;
	logic [15:0]   mul_a, mul_b;
	logic [31:0]   mul_p;
	logic          div_start, div_done;
	logic [31:0]   div_num;
	logic [QW-1:0] div_quo;

	logic [15:0] size_ci, count_ci, size_cls, count_cls;
	logic [15:0] base;
	logic [RB-1:0] eff;
	logic        found;
	logic [4:0]  fz;
	logic        out_free;
	logic        res_granted;

	function automatic logic [15:0] clamp(input logic [15:0] n);
		return (n > 16'(MAX_SLOTS)) ? 16'(MAX_SLOTS) : n;
	endfunction

	function automatic logic [AW-1:0] row_addr(input logic [2:0] c, input logic [WW-1:0] w);
		return AW'(c) * AW'(WPC) + AW'(w);
	endfunction

	// class lookups
	assign size_ci   = szal_pkg::field16(sizes_lo_q, sizes_hi_q, ci_q[2:0]);
	assign count_ci  = clamp(szal_pkg::field16(counts_lo_q, counts_hi_q, ci_q[2:0]));
	assign size_cls  = szal_pkg::field16(sizes_lo_q, sizes_hi_q, cls_q);
	assign count_cls = clamp(szal_pkg::field16(counts_lo_q, counts_hi_q, cls_q));

	// first free slot in the row just read; slots past the count read as used
	assign base = 16'(word_q) << 5;
	always_comb begin
		found = 1'b0;
		fz    = '0;
		for (int b = 0; b < RB; b++) begin
			eff[b] = rd_data[b] | ((base + 16'(b)) >= count_cls);
		end
		for (int b = RB - 1; b >= 0; b--) begin
			if (!eff[b]) begin
				found = 1'b1;
				fz    = 5'(b);
			end
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = size_ci;
		mul_b = count_ci;
		if (state_q == ST_AOFS) begin
			mul_a = slot_q;
			mul_b = size_cls;
		end
	end

	// memory ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = row_addr(cls_q, word_q);
		wr_en   = 1'b0;
		wr_addr = row_addr(cls_q, word_q);
		wr_data = rd_data | (RB'(1) << fz);
		case (state_q)
			ST_ARD: rd_en = 1'b1;
			ST_ACHK: wr_en = found;
			ST_RRD: begin
				rd_en   = 1'b1;
				rd_addr = row_addr(cls_q, WW'(slot_q >> 5));
			end
			ST_RWB: begin
				wr_en   = 1'b1;
				wr_addr = row_addr(cls_q, WW'(slot_q >> 5));
				wr_data = rd_data & ~(RB'(1) << slot_q[4:0]);
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == ST_RPC) && ({2'b0, rest_q} < mul_p);
	assign div_num   = 32'(rest_q) + 32'(size_ci) - 32'd1;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_lo_q  <= szal_pkg::SIZES_LO_RST;
			sizes_hi_q  <= szal_pkg::SIZES_HI_RST;
			counts_lo_q <= szal_pkg::COUNTS_LO_RST;
			counts_hi_q <= szal_pkg::COUNTS_HI_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				szal_pkg::CFG_SIZES_LO:  sizes_lo_q  <= cfg_data;
				szal_pkg::CFG_SIZES_HI:  sizes_hi_q  <= cfg_data;
				szal_pkg::CFG_COUNTS_LO: counts_lo_q <= cfg_data;
				szal_pkg::CFG_COUNTS_HI: counts_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			case (state_q)
				ST_CLR: if (!clearing) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (in_data.func == szal_pkg::FUNC_ALLOC) ? ST_ACLS : ST_RPI;
					end
				end
				ST_ACLS: begin
					if (ci_q == 4'(NUM_CLASSES) || req_q > 30'(size_ci)) begin
						state_q <= (ci_q == '0) ? ST_FIN : ST_ARD;
					end
				end
				ST_ARD: state_q <= ST_ACHK;
				ST_ACHK: begin
					if (found) begin
						state_q <= ST_AOFS;
					end else if (17'(base) + 17'd32 < 17'(count_cls)) begin
						state_q <= ST_ARD;
					end else begin
						state_q <= (cls_q == '0) ? ST_FIN : ST_ARD;
					end
				end
				ST_AOFS: state_q <= ST_AOFA;
				ST_AOFA: state_q <= ST_API;
				ST_API:  state_q <= (ci_q == {1'b0, cls_q}) ? ST_FIN : ST_APA;
				ST_APA:  state_q <= ST_API;
				ST_RPI:  state_q <= (ci_q == 4'(NUM_CLASSES)) ? ST_FIN : ST_RPC;
				ST_RPC:  state_q <= div_start ? ST_RDIV : ST_RPI;
				ST_RDIV: begin
					if (div_done) begin
						state_q <= (16'(div_quo) >= count_cls) ? ST_FIN : ST_RRD;
					end
				end
				ST_RRD:  state_q <= ST_RWB;
				ST_RWB:  state_q <= ST_FIN;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q  <= in_data.request_bytes;
				rest_q <= in_data.release_offset;
				ci_q   <= '0;
				res_q  <= '0;
			end
			ST_ACLS: begin
				if (ci_q == 4'(NUM_CLASSES) || req_q > 30'(size_ci)) begin
					res_q.status <= szal_pkg::ST_TOO_LARGE;
					cls_q        <= 3'(ci_q - 4'd1);
					word_q       <= '0;
				end else begin
					ci_q <= ci_q + 4'd1;
				end
			end
			ST_ACHK: begin
				if (found) begin
					slot_q <= base + 16'(fz);
				end else if (17'(base) + 17'd32 < 17'(count_cls)) begin
					word_q <= word_q + WW'(1);
				end else begin
					res_q.status <= szal_pkg::ST_NO_SLOT;
					cls_q        <= cls_q - 3'd1;
					word_q       <= '0;
				end
			end
			ST_AOFA: begin
				acc_q <= mul_p;
				ci_q  <= '0;
			end
			ST_API: begin
				res_q.grant_offset <= acc_q[29:0];
				res_q.status       <= szal_pkg::ST_GRANTED;
			end
			ST_APA: begin
				acc_q <= acc_q + mul_p;
				ci_q  <= ci_q + 4'd1;
			end
			ST_RPI: res_q.status <= szal_pkg::ST_BAD_OFFSET;
			ST_RPC: begin
				if (div_start) begin
					cls_q <= ci_q[2:0];
				end else begin
					rest_q <= rest_q - mul_p[29:0];
					ci_q   <= ci_q + 4'd1;
				end
			end
			ST_RDIV: slot_q <= 16'(div_quo);
			ST_RWB:  res_q.status <= szal_pkg::ST_RELEASED;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_q <= res_q;
		end
	end

	szal_bitmap #(.ROWS(ROWS), .AW(AW)) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	szal_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	szal_div #(.QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (size_ci),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign cfg_ready   = 1'b1;
	assign res_granted = (out_data.status == szal_pkg::ST_GRANTED);

	// checks
	`SZAL_ASSERT_NOW(a_clr_stall, clearing, in_stall)
	`SZAL_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
	`SZAL_ASSERT_NOW(a_status_code, out_valid, out_data.status <= szal_pkg::ST_BAD_OFFSET)
	`SZAL_ASSERT_NOW(a_grant_zero, out_valid && !res_granted, out_data.grant_offset == '0)

endmodule

`default_nettype wire
